/* design/rdbp_pkg.sv */
// rdbp_pkg: shared types, constants and codes for the bit-reversed pwm drive mixer
// no dependencies; imported by every module of the block

package rdbp_pkg;

  // pwm phase counter width and speed scale
  localparam int PHASE_BITS  = 6;
  localparam int SPEED_SHIFT = 6;                 // full speed is 2**SPEED_SHIFT
  localparam int FULL_SPEED  = 1 << SPEED_SHIFT;

  // field widths
  localparam int SPEED_W = 8;
  localparam int ANGLE_W = 12;
  localparam int MAG_W   = 7;
  localparam int FRAC_W  = 9;
  localparam int OCT_W   = ANGLE_W - FRAC_W;

  // stream packing
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  // item kind carried in tuser
  localparam logic KIND_WHEELS = 1'b0;
  localparam logic KIND_RADIAL = 1'b1;

  // octant codes, top bits of the angle
  typedef enum logic [OCT_W-1:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_e;

  typedef logic signed [SPEED_W-1:0] speed_t;

  // saturated speeds of both wheels
  typedef struct packed {
    speed_t left;
    speed_t right;
  } wheel_speeds_t;

  // h-bridge pin levels of one wheel
  typedef struct packed {
    logic fwd;
    logic rev;
  } bridge_pins_t;

endpackage

/* design/rdbp_mixer.sv */
// rdbp_mixer: turns one slot item into two saturated signed wheel speeds
// depends on rdbp_pkg

module rdbp_mixer
  import rdbp_pkg::*;
(
  input  logic                   kind_i,
  input  speed_t                 left_speed_i,
  input  speed_t                 right_speed_i,
  input  logic [ANGLE_W-1:0]     angle_i,
  input  logic [MAG_W-1:0]       magnitude_i,
  output wheel_speeds_t          speeds_o
);

  logic [MAG_W-1:0]      r_sat;
  logic [FRAC_W-1:0]     frac_f;
  logic [FRAC_W:0]       frac_g;
  logic [MAG_W+FRAC_W-1:0] prod_f;
  logic [MAG_W+FRAC_W:0]   prod_g;
  logic [MAG_W-1:0]      pf;
  logic [MAG_W-1:0]      pg;
  speed_t                rs_p, rs_n, pf_p, pf_n, pg_p, pg_n;
  speed_t                rad_left, rad_right;
  octant_e               oct;

  // saturate a direct wheel speed to +-full speed
  function automatic speed_t sat_speed(speed_t v);
    speed_t res;
    res = v;
    if (v > SPEED_W'(FULL_SPEED)) begin
      res = SPEED_W'(FULL_SPEED);
    end else if (v < -SPEED_W'(FULL_SPEED)) begin
      res = -SPEED_W'(FULL_SPEED);
    end
    return res;
  endfunction

  // magnitude clamp and octant fractions
  assign r_sat  = (magnitude_i > MAG_W'(FULL_SPEED)) ? MAG_W'(FULL_SPEED) : magnitude_i;
  assign frac_f = angle_i[FRAC_W-1:0];
  assign frac_g = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac_f};
  assign oct    = octant_e'(angle_i[ANGLE_W-1:FRAC_W]);

  // scaled magnitudes, truncated; both stay within full speed
  assign prod_f = (MAG_W+FRAC_W)'(r_sat) * (MAG_W+FRAC_W)'(frac_f);
  assign prod_g = (MAG_W+FRAC_W+1)'(r_sat) * (MAG_W+FRAC_W+1)'(frac_g);
  assign pf     = prod_f[MAG_W+FRAC_W-1:FRAC_W];
  assign pg     = prod_g[MAG_W+FRAC_W-1:FRAC_W];

  // signed forms
  assign rs_p = speed_t'({1'b0, r_sat});
  assign pf_p = speed_t'({1'b0, pf});
  assign pg_p = speed_t'({1'b0, pg});
  assign rs_n = -rs_p;
  assign pf_n = -pf_p;
  assign pg_n = -pg_p;

  // octant mixing rules
  always_comb begin
    unique case (oct)
      OCT_0: begin rad_left = rs_p; rad_right = pg_p; end
      OCT_1: begin rad_left = rs_p; rad_right = pf_n; end
      OCT_2: begin rad_left = pg_p; rad_right = rs_n; end
      OCT_3: begin rad_left = pf_n; rad_right = rs_n; end
      OCT_4: begin rad_left = rs_n; rad_right = pg_n; end
      OCT_5: begin rad_left = rs_n; rad_right = pf_p; end
      OCT_6: begin rad_left = pg_n; rad_right = rs_p; end
      default: begin rad_left = pf_p; rad_right = rs_p; end
    endcase
  end

  // mode select
  always_comb begin
    if (kind_i == KIND_RADIAL) begin
      speeds_o.left  = rad_left;
      speeds_o.right = rad_right;
    end else begin
      speeds_o.left  = sat_speed(left_speed_i);
      speeds_o.right = sat_speed(right_speed_i);
    end
  end

endmodule

/* design/rdbp_pulse.sv */
// rdbp_pulse: compares one wheel's speed with the reversed phase and drives its pins
// depends on rdbp_pkg

module rdbp_pulse
  import rdbp_pkg::*;
(
  input  speed_t                 speed_i,
  input  logic [PHASE_BITS-1:0]  rev_phase_i,
  output bridge_pins_t           pins_o
);

  localparam int CMP_W = PHASE_BITS + MAG_W;

  logic [SPEED_W-1:0] abs_speed;
  logic [MAG_W-1:0]   mag;
  logic [CMP_W-1:0]   lhs;
  logic [CMP_W-1:0]   rhs;
  logic               on;

  // speed is already within +-full speed, so the magnitude fits
  assign abs_speed = speed_i[SPEED_W-1] ? SPEED_W'(-speed_i) : SPEED_W'(speed_i);
  assign mag       = abs_speed[MAG_W-1:0];

  // on while rev * full_speed < mag * 2**phase_bits
  assign lhs = CMP_W'({rev_phase_i, {SPEED_SHIFT{1'b0}}});
  assign rhs = {mag, {PHASE_BITS{1'b0}}};
  assign on  = lhs < rhs;

  // sign picks the driven pin
  assign pins_o.fwd = on & ~speed_i[SPEED_W-1];
  assign pins_o.rev = on &  speed_i[SPEED_W-1];

endmodule

/* design/radial_drive_bitrev_pwm_top.sv */
// radial_drive_bitrev_pwm_top: stream wrapper, phase counter and registers of the mixer
// depends on rdbp_pkg, rdbp_mixer, rdbp_pulse

// Each accepted item is one pwm slot and yields one item of four h-bridge pin levels.
// Items go through an input register, then the mixer and the per-wheel compare, then
// the result register, one item per cycle sustained while m_axis_tready keeps the result
// register draining. The input side stalls only when the result register holds an
// item not yet taken and the input register is full. The 6-bit phase counter
// advances on every accepted item, so the first item after reset uses phase 1.

module radial_drive_bitrev_pwm_top
  import rdbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: left_speed[7:0], right_speed[15:8], angle[27:16], magnitude[34:28], zero pad
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind[0]
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: left_forward[0], left_reverse[1], right_forward[2], right_reverse[3], zero pad
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready
);

  logic                   s_accept;
  logic                   s1_adv;
  logic                   s1_valid_q, s1_valid_d;
  logic [S_DATA_W-1:0]    s1_data_q;
  logic                   s1_kind_q;
  logic [PHASE_BITS-1:0]  s1_phase_q;
  logic [PHASE_BITS-1:0]  phase_q, phase_d;
  logic [PHASE_BITS-1:0]  rev_phase;
  logic                   m_valid_q, m_valid_d;
  logic [3:0]             m_pins_q;
  wheel_speeds_t          speeds;
  bridge_pins_t           left_pins, right_pins;

  // handshake and pipeline advance
  assign s1_adv        = ~m_valid_q | m_axis_tready;
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign phase_d       = phase_q + PHASE_BITS'(1);

  // control registers
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (s1_adv) begin
      m_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (s_accept) begin
        phase_q <= phase_d;
      end
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // input register with the slot phase
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_data_q  <= s_axis_tdata;
      s1_kind_q  <= s_axis_tuser;
      s1_phase_q <= phase_d;
    end
  end

  // bit reversal of the slot phase
  always_comb begin
    for (int b = 0; b < PHASE_BITS; b++) begin
      rev_phase[b] = s1_phase_q[PHASE_BITS-1-b];
    end
  end

  rdbp_mixer u_mixer (
    .kind_i        (s1_kind_q),
    .left_speed_i  (speed_t'(s1_data_q[7:0])),
    .right_speed_i (speed_t'(s1_data_q[15:8])),
    .angle_i       (s1_data_q[27:16]),
    .magnitude_i   (s1_data_q[34:28]),
    .speeds_o      (speeds)
  );

  rdbp_pulse u_pulse_left (
    .speed_i     (speeds.left),
    .rev_phase_i (rev_phase),
    .pins_o      (left_pins)
  );

  rdbp_pulse u_pulse_right (
    .speed_i     (speeds.right),
    .rev_phase_i (rev_phase),
    .pins_o      (right_pins)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      m_pins_q <= {right_pins.rev, right_pins.fwd, left_pins.rev, left_pins.fwd};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W-4){1'b0}}, m_pins_q};

`ifndef ASSERT_OFF
  // a wheel never drives both bridge pins
  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_pins_q[0] && m_pins_q[1]) && !(m_pins_q[2] && m_pins_q[3]))
    else $error("both pins of one wheel driven");

  // phase counter steps by one per accepted item
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> phase_q == $past(phase_d))
    else $error("phase counter did not advance");

  // a held input item stays while the result register is stalled
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q && $stable(s1_phase_q))
    else $error("input register lost an item");

  // a new result only comes from a held input item
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(s1_valid_q))
    else $error("result without an item");
`endif

endmodule

/* bench/tb_radial_drive_bitrev_pwm_top.sv */
// tb_radial_drive_bitrev_pwm_top: self-checking bench for the bit-reversed pwm drive mixer
// drives directed and random slots with random gaps and back-pressure and checks each
// result against an in-bench model; depends on rdbp_pkg and radial_drive_bitrev_pwm_top

`timescale 1ns / 100ps

module tb_radial_drive_bitrev_pwm_top;
  import rdbp_pkg::*;

  localparam int ANGLE_LSB   = 2 * SPEED_W;
  localparam int MAG_LSB     = ANGLE_LSB + ANGLE_W;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int RAND_SLOTS  = 900;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic                s_axis_tuser  = KIND_WHEELS;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  // expected pin levels, oldest first
  logic [M_DATA_W-1:0]   pin_levels_q[$];
  logic [PHASE_BITS-1:0] slot_phase  = '0;
  logic                  steady_run  = 1'b0;
  int                    mismatches  = 0;
  int                    stall_cycles = 0;

  radial_drive_bitrev_pwm_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // wheel speed limited to full scale
  function automatic int clamp_speed(input int s);
    if (s > FULL_SPEED) return FULL_SPEED;
    if (s < -FULL_SPEED) return -FULL_SPEED;
    return s;
  endfunction

  // wheel pulse is on when the reversed phase lies below the duty
  function automatic logic pulse_on(input int s, input int rev);
    int mag;
    mag = (s < 0) ? -s : s;
    return (rev * FULL_SPEED) < (mag << PHASE_BITS);
  endfunction

  // pin levels for one slot at the given phase
  function automatic logic [M_DATA_W-1:0] drive_pins(input logic kind,
                                                      input logic [S_DATA_W-1:0] data,
                                                      input logic [PHASE_BITS-1:0] phase);
    speed_t              ls, rs;
    octant_e             oct;
    int                  left, right, r, f, pf, pg, rev, b;
    logic [M_DATA_W-1:0] pins;
    ls  = data[0 +: SPEED_W];
    rs  = data[SPEED_W +: SPEED_W];
    f   = int'(data[ANGLE_LSB +: FRAC_W]);
    oct = octant_e'(data[ANGLE_LSB + FRAC_W +: OCT_W]);
    r   = int'(data[MAG_LSB +: MAG_W]);
    if (r > FULL_SPEED) r = FULL_SPEED;
    pf  = (r * f) >> FRAC_W;
    pg  = (r * ((1 << FRAC_W) - f)) >> FRAC_W;
    if (kind == KIND_WHEELS) begin
      left  = clamp_speed(ls);
      right = clamp_speed(rs);
    end else begin
      // octant mixing rules
      unique case (oct)
        OCT_0: begin left = r;   right = pg;  end
        OCT_1: begin left = r;   right = -pf; end
        OCT_2: begin left = pg;  right = -r;  end
        OCT_3: begin left = -pf; right = -r;  end
        OCT_4: begin left = -r;  right = -pg; end
        OCT_5: begin left = -r;  right = pf;  end
        OCT_6: begin left = -pg; right = r;   end
        default: begin left = pf; right = r;  end
      endcase
    end
    rev = 0;
    for (b = 0; b < PHASE_BITS; b++)
      if (phase[b]) rev |= 1 << (PHASE_BITS - 1 - b);
    pins    = '0;
    pins[0] = (left > 0) && pulse_on(left, rev);
    pins[1] = (left < 0) && pulse_on(left, rev);
    pins[2] = (right > 0) && pulse_on(right, rev);
    pins[3] = (right < 0) && pulse_on(right, rev);
    return pins;
  endfunction

  // input and output monitors, random back-pressure
  always @(posedge clk_i) begin
    logic [M_DATA_W-1:0] want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      slot_phase = slot_phase + 1'b1;
      pin_levels_q.push_back(drive_pins(s_axis_tuser, s_axis_tdata, slot_phase));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pin_levels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: lf=%b lr=%b rf=%b rr=%b data=%h", m_axis_tdata[0],
                   m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[3], m_axis_tdata);
      end else begin
        want = pin_levels_q.pop_front();
        if (m_axis_tdata[0] !== want[0] || m_axis_tdata[1] !== want[1] ||
            m_axis_tdata[2] !== want[2] || m_axis_tdata[3] !== want[3] ||
            m_axis_tdata[M_DATA_W-1:4] !== want[M_DATA_W-1:4]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: lf/lr/rf/rr expected %b%b%b%b got %b%b%b%b (data %h vs %h)",
                     want[0], want[1], want[2], want[3], m_axis_tdata[0], m_axis_tdata[1],
                     m_axis_tdata[2], m_axis_tdata[3], want, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= steady_run ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb_radial_drive_bitrev_pwm_top NOT OK");
      $finish;
    end
  end

  // send one slot, with a random gap ahead of it
  task automatic send_slot(input logic kind, input int left, input int right,
                           input int angle, input int mag);
    logic [S_DATA_W-1:0] data;
    while (!steady_run && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    data = '0;
    data[0 +: SPEED_W]       = left[SPEED_W-1:0];
    data[SPEED_W +: SPEED_W] = right[SPEED_W-1:0];
    data[ANGLE_LSB +: ANGLE_W] = angle[ANGLE_W-1:0];
    data[MAG_LSB +: MAG_W]   = mag[MAG_W-1:0];
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // wait until every expected item has come, then let the clock run on
  task automatic wait_drain();
    while (pin_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // direct speeds: zero, full scale both ways, saturation, smallest steps
  task automatic test_wheels_directed();
    send_slot(KIND_WHEELS, 0, 0, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, 64, -64, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, -64, 64, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, 127, -128, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, 65, -65, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, 1, -1, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, -1, 1, $urandom_range(4095), $urandom_range(127));
    send_slot(KIND_WHEELS, 63, 0, $urandom_range(4095), $urandom_range(127));
  endtask

  // radial: every octant, fraction edges, zero and saturated magnitude
  task automatic test_radial_directed();
    int o;
    for (o = 0; o < 8; o++)
      send_slot(KIND_RADIAL, $urandom_range(255), $urandom_range(255),
                (o << FRAC_W) | $urandom_range(511), FULL_SPEED);
    send_slot(KIND_RADIAL, $urandom_range(255), $urandom_range(255), 0, FULL_SPEED);
    send_slot(KIND_RADIAL, $urandom_range(255), $urandom_range(255), 4095, FULL_SPEED);
    send_slot(KIND_RADIAL, $urandom_range(255), $urandom_range(255), 1535, 0);
    send_slot(KIND_RADIAL, $urandom_range(255), $urandom_range(255), 2560, 127);
    send_slot(KIND_RADIAL, $urandom_range(255), $urandom_range(255), 511, 65);
  endtask

  // random mix of both kinds, with one stretch free of gaps and stalls
  task automatic test_random_slots();
    int i, left, right, mag;
    for (i = 0; i < RAND_SLOTS; i++) begin
      steady_run = (i >= 300 && i < 450);
      if ($urandom_range(9) == 0) begin
        left  = $urandom_range(255);
        right = $urandom_range(255);
      end else begin
        left  = $urandom_range(128) - 64;
        right = $urandom_range(128) - 64;
      end
      mag = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(FULL_SPEED);
      send_slot(1'($urandom_range(1)), left, right, $urandom_range(4095), mag);
    end
    steady_run = 1'b0;
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_wheels_directed();
    test_radial_directed();
    test_random_slots();
    s_axis_tvalid <= 1'b0;
    wait_drain();
    if (mismatches == 0)
      $display("tb_radial_drive_bitrev_pwm_top OK");
    else
      $display("tb_radial_drive_bitrev_pwm_top NOT OK");
    $finish;
  end

endmodule

/* files.f */
design/rdbp_pkg.sv
design/rdbp_mixer.sv
design/rdbp_pulse.sv
design/radial_drive_bitrev_pwm_top.sv
bench/tb_radial_drive_bitrev_pwm_top.sv
